### sv/aeia_pkg.sv
`default_nettype none
package aeia_pkg;

  localparam int NUM_X      = 256;
  localparam int NUM_Y      = 256;
  localparam int PIXEL_BITS = 10;
  localparam int COUNT_BITS = 32;
  localparam int CELLS      = NUM_X * NUM_Y;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int XB         = $clog2(NUM_X);
  localparam int YB         = $clog2(NUM_Y);

  localparam int DITHER_W = 16;
  localparam int BIN_W    = 8;
  localparam int COEF_W   = 21;
  localparam int OFFS_W   = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;

  localparam int POS_W  = PIXEL_BITS + DITHER_W;
  localparam int PROD_W = COEF_W + POS_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int IDX_W  = SUM_W - 32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_XX  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DITHER   = 3'd6;

  typedef struct packed {
    logic                  command;
    logic [PIXEL_BITS-1:0] pixel_x;
    logic [PIXEL_BITS-1:0] pixel_y;
    logic [DITHER_W-1:0]   dither_x;
    logic [DITHER_W-1:0]   dither_y;
    logic [BIN_W-1:0]      read_bin_x;
    logic [BIN_W-1:0]      read_bin_y;
  } in_item_t;

  typedef struct packed {
    logic                  kind;
    logic                  in_range;
    logic [BIN_W-1:0]      bin_x;
    logic [BIN_W-1:0]      bin_y;
    logic [COUNT_BITS-1:0] count;
  } out_item_t;

  typedef struct packed {
    logic              kind;
    logic              in_range;
    logic [BIN_W-1:0]  bin_x;
    logic [BIN_W-1:0]  bin_y;
    logic [ADDR_W-1:0] addr;
  } q_item_t;

endpackage
`default_nettype wire

### sv/affine_event_image_accumulator.sv
// Affine event image accumulator: a 256 x 256 image of 32-bit saturating
// counts, filled by events mapped through a programmable 2x2 affine transform.
// Input channel: a queue write port (push, full). An item is either an event
// to add or a read of one bin. Result channel: a queue read port (empty, pop);
// every item gives exactly one result item, in order.
// Config channel: cfg_valid_i/cfg_ready_o with index and data; ready is always
// high. Write registers only while the block is idle.
// Flow: an accepted item passes through the front's multiply, sum and
// classify, and hand-off states, then through the back's memory read and its
// update and write. The front takes one item at a time and holds full high
// until it has handed that item to the queue; the back's read-modify-write of
// the single-port image memory overlaps with it.
// Reset: the configuration returns to identity and the image memory is zeroed
// by a clearing pass over all 65536 bins, one bin per cycle; full stays high
// during the pass.
// A stalled receiver holds the result in the output register; the back then
// stops, the two-entry queue between front and back fills, and full rises.
`default_nettype none
module affine_event_image_accumulator (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [aeia_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [aeia_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                             push,
  output logic                                  full,
  input  wire aeia_pkg::in_item_t               in_item_i,
  output logic                                  empty,
  input  wire logic                             pop,
  output aeia_pkg::out_item_t                   out_item_o
);

  logic              clearing;
  logic              q_push, q_full, q_pop, q_empty;
  aeia_pkg::q_item_t q_wr_item, q_rd_item;

  assign cfg_ready_o = 1'b1;

  aeia_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .full_o      (full),
    .in_item_i   (in_item_i),
    .clearing_i  (clearing),
    .q_push_o    (q_push),
    .q_full_i    (q_full),
    .q_item_o    (q_wr_item)
  );

  aeia_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_rd_item),
    .empty_o (q_empty)
  );

  aeia_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clearing_o (clearing),
    .q_empty_i  (q_empty),
    .q_item_i   (q_rd_item),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule
`default_nettype wire

### sv/aeia_front.sv
`default_nettype none
module aeia_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  input  wire logic [aeia_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [aeia_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                             push_i,
  output logic                                  full_o,
  input  wire aeia_pkg::in_item_t               in_item_i,
  input  wire logic                             clearing_i,
  output logic                                  q_push_o,
  input  wire logic                             q_full_i,
  output aeia_pkg::q_item_t                     q_item_o
);

  localparam int PW = aeia_pkg::PROD_W;
  localparam int SW = aeia_pkg::SUM_W;
  localparam int IW = aeia_pkg::IDX_W;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_SUM  = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_e;

  front_state_e state_q, state_d;

  logic signed [aeia_pkg::COEF_W-1:0] coef_xx_q, coef_xy_q, coef_yx_q, coef_yy_q;
  logic signed [aeia_pkg::OFFS_W-1:0] offset_x_q, offset_y_q;
  logic                               dither_en_q;

  aeia_pkg::in_item_t in_q;
  aeia_pkg::q_item_t  item_q, item_d;

  logic signed [PW-1:0] prod_xx_q, prod_xy_q, prod_yx_q, prod_yy_q;
  logic signed [PW-1:0] prod_xx_d, prod_xy_d, prod_yx_d, prod_yy_d;
  logic [aeia_pkg::POS_W-1:0] px, py;
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [IW-1:0] ix, iy;
  logic                 ok_x, ok_y, hit;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_xx_q   <= 21'sd65536;
      coef_xy_q   <= '0;
      coef_yx_q   <= '0;
      coef_yy_q   <= 21'sd65536;
      offset_x_q  <= '0;
      offset_y_q  <= '0;
      dither_en_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        aeia_pkg::REG_COEF_XX:  coef_xx_q   <= cfg_data_i[aeia_pkg::COEF_W-1:0];
        aeia_pkg::REG_COEF_XY:  coef_xy_q   <= cfg_data_i[aeia_pkg::COEF_W-1:0];
        aeia_pkg::REG_COEF_YX:  coef_yx_q   <= cfg_data_i[aeia_pkg::COEF_W-1:0];
        aeia_pkg::REG_COEF_YY:  coef_yy_q   <= cfg_data_i[aeia_pkg::COEF_W-1:0];
        aeia_pkg::REG_OFFSET_X: offset_x_q  <= cfg_data_i[aeia_pkg::OFFS_W-1:0];
        aeia_pkg::REG_OFFSET_Y: offset_y_q  <= cfg_data_i[aeia_pkg::OFFS_W-1:0];
        aeia_pkg::REG_DITHER:   dither_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign full_o = (state_q != F_IDLE) || clearing_i;

  // multiply stage
  always_comb begin
    px = {in_q.pixel_x, dither_en_q ? in_q.dither_x : {aeia_pkg::DITHER_W{1'b0}}};
    py = {in_q.pixel_y, dither_en_q ? in_q.dither_y : {aeia_pkg::DITHER_W{1'b0}}};
    prod_xx_d = PW'(coef_xx_q) * $signed(PW'(px));
    prod_xy_d = PW'(coef_xy_q) * $signed(PW'(py));
    prod_yx_d = PW'(coef_yx_q) * $signed(PW'(px));
    prod_yy_d = PW'(coef_yy_q) * $signed(PW'(py));
  end

  // sum, floor and classify
  always_comb begin
    sum_x = SW'(prod_xx_q) + SW'(prod_xy_q) + (SW'(offset_x_q) <<< 16);
    sum_y = SW'(prod_yx_q) + SW'(prod_yy_q) + (SW'(offset_y_q) <<< 16);
    if (in_q.command == aeia_pkg::CMD_ADD) begin
      ix = sum_x[SW-1:32];
      iy = sum_y[SW-1:32];
    end else begin
      ix = $signed(IW'(in_q.read_bin_x));
      iy = $signed(IW'(in_q.read_bin_y));
    end
    ok_x = !ix[IW-1] && (ix < $signed(IW'(aeia_pkg::NUM_X)));
    ok_y = !iy[IW-1] && (iy < $signed(IW'(aeia_pkg::NUM_Y)));
    hit  = ok_x && ok_y;
    item_d.kind     = in_q.command;
    item_d.in_range = hit;
    item_d.bin_x    = hit ? ix[aeia_pkg::BIN_W-1:0] : '0;
    item_d.bin_y    = hit ? iy[aeia_pkg::BIN_W-1:0] : '0;
    item_d.addr     = hit
      ? aeia_pkg::ADDR_W'(aeia_pkg::ADDR_W'(ix[aeia_pkg::XB-1:0])
                          * aeia_pkg::ADDR_W'(aeia_pkg::NUM_Y)
                          + aeia_pkg::ADDR_W'(iy[aeia_pkg::YB-1:0]))
      : '0;
  end

  always_comb begin
    state_d  = state_q;
    q_push_o = 1'b0;
    case (state_q)
      F_IDLE: if (push_i && !full_o) state_d = F_MUL;
      F_MUL:  state_d = F_SUM;
      F_SUM:  state_d = F_PUSH;
      F_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && push_i && !full_o) begin
      in_q <= in_item_i;
    end
    if (state_q == F_MUL) begin
      prod_xx_q <= prod_xx_d;
      prod_xy_q <= prod_xy_d;
      prod_yx_q <= prod_yx_d;
      prod_yy_q <= prod_yy_d;
    end
    if (state_q == F_SUM) begin
      item_q <= item_d;
    end
  end

  assign q_item_o = item_q;

endmodule
`default_nettype wire

### sv/aeia_fifo.sv
`default_nettype none
module aeia_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire aeia_pkg::q_item_t item_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output aeia_pkg::q_item_t      item_o,
  output logic                   empty_o
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  aeia_pkg::q_item_t slot_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [PTR_W:0]    cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (PTR_W + 1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= item_i;
  end

endmodule
`default_nettype wire

### sv/aeia_back.sv
`default_nettype none
module aeia_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  output logic                   clearing_o,
  input  wire logic              q_empty_i,
  input  wire aeia_pkg::q_item_t q_item_i,
  output logic                   q_pop_o,
  output logic                   empty_o,
  input  wire logic              pop_i,
  output aeia_pkg::out_item_t    out_item_o
);

  localparam int AW = aeia_pkg::ADDR_W;
  localparam int CW = aeia_pkg::COUNT_BITS;

  typedef enum logic [2:0] {
    B_CLEAR = 3'b001,
    B_IDLE  = 3'b010,
    B_RMW   = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;

  logic [CW-1:0] mem [aeia_pkg::CELLS];
  logic [CW-1:0] rdata_q;
  logic [AW-1:0] clr_q;

  aeia_pkg::q_item_t   cur_q;
  aeia_pkg::out_item_t out_q, out_d;
  logic                out_valid_q;

  logic          slot_free, load_out;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;
  logic [CW-1:0] new_count;

  assign clearing_o = (state_q == B_CLEAR);
  assign slot_free  = !out_valid_q || pop_i;
  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  always_comb begin
    new_count = rdata_q;
    if (cur_q.kind == aeia_pkg::CMD_ADD && rdata_q != aeia_pkg::COUNT_MAX) begin
      new_count = rdata_q + 1'b1;
    end
    out_d.kind     = cur_q.kind;
    out_d.in_range = cur_q.in_range;
    out_d.bin_x    = cur_q.bin_x;
    out_d.bin_y    = cur_q.bin_y;
    out_d.count    = cur_q.in_range ? new_count : '0;
  end

  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur_q.addr;
    mem_wdata = new_count;
    load_out  = 1'b0;
    case (state_q)
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == AW'(aeia_pkg::CELLS - 1)) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          mem_re  = 1'b1;
          state_d = B_RMW;
        end
      end
      B_RMW: begin
        if (slot_free) begin
          load_out = 1'b1;
          mem_we   = cur_q.in_range && (cur_q.kind == aeia_pkg::CMD_ADD);
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) clr_q <= clr_q + 1'b1;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o)  cur_q <= q_item_i;
    if (load_out) out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[q_item_i.addr];
  end

endmodule
`default_nettype wire
